>>> rtl/bjts_pkg.sv
// ----------------------------------------------------------------------------
// bjts_pkg
// Shared types, codes and defaults for the binary Jaccard top-k search block.
// ----------------------------------------------------------------------------
`default_nettype none

package bjts_pkg;

  // Field widths fixed by the interface
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned INDEX_W   = 20;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned NCOUNT_W  = 5;

  // Parameter defaults
  localparam int unsigned DEF_VECTOR_WORDS = 2;
  localparam int unsigned DEF_K_MAX        = 16;
  localparam int unsigned DEF_MAX_VECTORS  = 1048576;

  localparam logic [NCOUNT_W-1:0] NCOUNT_RESET = 5'd1;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DB    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // transaction taken this cycle
    logic insert;  // run the list insertion for the latched candidate
    logic emit;    // report the head of the list
  } bjts_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ins_req;    // accepted word closes a vector that goes into the list
    logic flush_req;  // accepted item is a flush
    logic last_emit;  // current report is the last of the flush
  } bjts_stat_t;

endpackage

`default_nettype wire

>>> rtl/bjts_ctrl.sv
// ----------------------------------------------------------------------------
// bjts_ctrl
// Sequencer: takes transactions, then runs insertion or flush reporting.
// ----------------------------------------------------------------------------
`default_nettype none

module bjts_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  output logic                busy_o,
  input  bjts_pkg::bjts_stat_t stat_i,
  output bjts_pkg::bjts_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_INSERT = 2'd1;
  localparam logic [1:0] ST_FLUSH  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && stat_i.ins_req) begin
          state_d = ST_INSERT;
        end else if (accept && stat_i.flush_req) begin
          state_d = ST_FLUSH;
        end
      end
      ST_INSERT: begin
        state_d = ST_IDLE;
      end
      ST_FLUSH: begin
        if (stat_i.last_emit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.accept = accept;
  assign cmd_o.insert = (state_q == ST_INSERT);
  assign cmd_o.emit   = (state_q == ST_FLUSH);

  // Insertion always returns to idle on the following cycle
  a_insert_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INSERT) |=> (state_q == ST_IDLE))
    else $error("insertion did not return to idle");

endmodule

`default_nettype wire

>>> rtl/bjts_datapath.sv
// ----------------------------------------------------------------------------
// bjts_datapath
// Query store, popcount accumulators, sorted neighbour cells, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bjts_datapath #(
  parameter int unsigned VECTOR_WORDS = bjts_pkg::DEF_VECTOR_WORDS,
  parameter int unsigned K_MAX        = bjts_pkg::DEF_K_MAX,
  parameter int unsigned MAX_VECTORS  = bjts_pkg::DEF_MAX_VECTORS
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  bjts_pkg::bjts_cmd_t               cmd_i,
  output bjts_pkg::bjts_stat_t              stat_o,
  input  wire [bjts_pkg::ACT_W-1:0]         action_i,
  input  wire [bjts_pkg::WORD_W-1:0]        data_word_i,
  input  wire                               final_word_i,
  input  wire                               cfg_we_i,
  input  wire [bjts_pkg::NCOUNT_W-1:0]      cfg_wdata_i,
  output logic                              result_valid_o,
  output logic [bjts_pkg::INDEX_W-1:0]      neighbour_index_o,
  output logic [bjts_pkg::COUNT_W-1:0]      common_bits_o,
  output logic [bjts_pkg::COUNT_W-1:0]      either_bits_o,
  output logic                              entry_valid_o,
  output logic                              run_end_o
);

  localparam int unsigned PW   = (VECTOR_WORDS > 1) ? $clog2(VECTOR_WORDS) : 1;
  localparam int unsigned AW   = $clog2(bjts_pkg::WORD_W * VECTOR_WORDS + 1);
  localparam int unsigned PRW  = 2 * AW;
  localparam int unsigned CW   = $clog2(MAX_VECTORS + 1);
  localparam int unsigned IW   = $clog2(MAX_VECTORS);
  localparam int unsigned FW   = $clog2(K_MAX + 1);
  localparam int unsigned OW   = bjts_pkg::INDEX_W;
  localparam int unsigned SATW = bjts_pkg::COUNT_W;

  // Adder-tree popcount of one word
  function automatic logic [6:0] popcount64(input logic [63:0] v);
    logic [1:0] s1 [32];
    logic [2:0] s2 [16];
    logic [3:0] s3 [8];
    logic [4:0] s4 [4];
    logic [5:0] s5 [2];
    for (int i = 0; i < 32; i++) s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 16; i++) s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    for (int i = 0; i < 8; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    for (int i = 0; i < 4; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    for (int i = 0; i < 2; i++)  s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    return {1'b0, s5[0]} + {1'b0, s5[1]};
  endfunction

  function automatic logic [SATW-1:0] sat_count(input logic [AW-1:0] c);
    return (32'(c) > 255) ? {SATW{1'b1}} : SATW'(c);
  endfunction

  // Configuration
  logic [bjts_pkg::NCOUNT_W-1:0] ncount_q;

  // Vector accumulation state
  logic [bjts_pkg::WORD_W-1:0] query_q [VECTOR_WORDS];
  logic [PW-1:0] pos_q, pos_d;
  logic [AW-1:0] acc_and_q, acc_and_d, acc_or_q, acc_or_d;
  logic [CW-1:0] vcnt_q, vcnt_d;

  // Candidate waiting for insertion
  logic [IW-1:0] cand_idx_q;
  logic [AW-1:0] cand_and_q, cand_or_q;

  // Sorted neighbour cells
  logic [IW-1:0] cell_idx_q [K_MAX];
  logic [AW-1:0] cell_and_q [K_MAX];
  logic [AW-1:0] cell_or_q  [K_MAX];
  logic [IW-1:0] cell_idx_d [K_MAX];
  logic [AW-1:0] cell_and_d [K_MAX];
  logic [AW-1:0] cell_or_d  [K_MAX];
  logic [FW-1:0] fill_q, fill_d;

  // Flush reporting
  logic [FW-1:0] rem_q, rem_d;
  logic          empty_q, empty_d;

  logic [bjts_pkg::WORD_W-1:0] qword;
  logic [AW-1:0]               sum_and, sum_or;
  logic                        vec_end, cnt_ok;
  logic [FW-1:0]               k_lim, fill_eff;
  logic                        flag      [K_MAX];
  logic                        prev_flag [K_MAX];
  logic [AW-1:0]               cand_and_n, cand_or_n;
  logic [AW-1:0]               cell_and_n [K_MAX];
  logic [AW-1:0]               cell_or_n  [K_MAX];
  logic [PRW-1:0]              prod_new   [K_MAX];
  logic [PRW-1:0]              prod_cell  [K_MAX];
  logic [IW+OW-1:0]            idx_ext;

  assign qword   = query_q[pos_q];
  assign sum_and = acc_and_q + AW'(popcount64(qword & data_word_i));
  assign sum_or  = acc_or_q  + AW'(popcount64(qword | data_word_i));
  assign vec_end = final_word_i || (pos_q == PW'(VECTOR_WORDS - 1));
  assign cnt_ok  = (vcnt_q < CW'(MAX_VECTORS));

  // Effective neighbour count: zero acts as one, clipped to the cell count
  always_comb begin
    if (ncount_q == '0) begin
      k_lim = FW'(1);
    end else if (32'(ncount_q) > 32'(K_MAX)) begin
      k_lim = FW'(K_MAX);
    end else begin
      k_lim = FW'(ncount_q);
    end
    fill_eff = (fill_q > k_lim) ? k_lim : fill_q;
  end

  assign stat_o.ins_req   = (action_i == bjts_pkg::ACT_DB) && vec_end && cnt_ok;
  assign stat_o.flush_req = (action_i == bjts_pkg::ACT_FLUSH);
  assign stat_o.last_emit = (rem_q == FW'(1));

  // Per-cell distance compare by cross-multiplication; empty union is (0, 1)
  assign cand_and_n = (cand_or_q == '0) ? '0 : cand_and_q;
  assign cand_or_n  = (cand_or_q == '0) ? AW'(1) : cand_or_q;

  always_comb begin
    for (int j = 0; j < K_MAX; j++) begin
      cell_and_n[j] = (cell_or_q[j] == '0) ? '0 : cell_and_q[j];
      cell_or_n[j]  = (cell_or_q[j] == '0) ? AW'(1) : cell_or_q[j];
      prod_new[j]   = PRW'(cand_and_n) * PRW'(cell_or_n[j]);
      prod_cell[j]  = PRW'(cell_and_n[j]) * PRW'(cand_or_n);
      // Flags are monotonic over the sorted list: first set flag is the slot
      flag[j]       = (j >= int'(fill_eff)) || (prod_new[j] > prod_cell[j]);
    end
    prev_flag[0] = 1'b0;
    for (int j = 1; j < K_MAX; j++) begin
      prev_flag[j] = flag[j-1];
    end
  end

  // Cell next values: insert with shift up, or shift down while reporting
  always_comb begin
    for (int j = 0; j < K_MAX; j++) begin
      cell_idx_d[j] = cell_idx_q[j];
      cell_and_d[j] = cell_and_q[j];
      cell_or_d[j]  = cell_or_q[j];
    end
    if (cmd_i.insert) begin
      if (flag[0]) begin
        cell_idx_d[0] = cand_idx_q;
        cell_and_d[0] = cand_and_q;
        cell_or_d[0]  = cand_or_q;
      end
      for (int j = 1; j < K_MAX; j++) begin
        if (prev_flag[j]) begin
          cell_idx_d[j] = cell_idx_q[j-1];
          cell_and_d[j] = cell_and_q[j-1];
          cell_or_d[j]  = cell_or_q[j-1];
        end else if (flag[j]) begin
          cell_idx_d[j] = cand_idx_q;
          cell_and_d[j] = cand_and_q;
          cell_or_d[j]  = cand_or_q;
        end
      end
    end else if (cmd_i.emit) begin
      for (int j = 0; j + 1 < K_MAX; j++) begin
        cell_idx_d[j] = cell_idx_q[j+1];
        cell_and_d[j] = cell_and_q[j+1];
        cell_or_d[j]  = cell_or_q[j+1];
      end
    end
  end

  // Control-state next values
  always_comb begin
    pos_d     = pos_q;
    acc_and_d = acc_and_q;
    acc_or_d  = acc_or_q;
    vcnt_d    = vcnt_q;
    fill_d    = fill_q;
    rem_d     = rem_q;
    empty_d   = empty_q;
    if (cmd_i.accept) begin
      unique case (action_i)
        bjts_pkg::ACT_QUERY: begin
          acc_and_d = '0;
          acc_or_d  = '0;
          pos_d     = vec_end ? '0 : pos_q + PW'(1);
        end
        bjts_pkg::ACT_DB: begin
          pos_d = vec_end ? '0 : pos_q + PW'(1);
          if (vec_end) begin
            acc_and_d = '0;
            acc_or_d  = '0;
            if (cnt_ok) begin
              vcnt_d = vcnt_q + CW'(1);
            end
          end else begin
            acc_and_d = sum_and;
            acc_or_d  = sum_or;
          end
        end
        bjts_pkg::ACT_FLUSH: begin
          pos_d     = '0;
          acc_and_d = '0;
          acc_or_d  = '0;
          vcnt_d    = '0;
          fill_d    = '0;
          empty_d   = (fill_eff == '0);
          rem_d     = (fill_eff == '0) ? FW'(1) : fill_eff;
        end
        default: begin
          // unknown action: drop
        end
      endcase
    end else if (cmd_i.insert) begin
      fill_d = (fill_eff < k_lim) ? fill_eff + FW'(1) : k_lim;
    end else if (cmd_i.emit) begin
      rem_d = rem_q - FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncount_q       <= bjts_pkg::NCOUNT_RESET;
      pos_q          <= '0;
      acc_and_q      <= '0;
      acc_or_q       <= '0;
      vcnt_q         <= '0;
      fill_q         <= '0;
      rem_q          <= '0;
      empty_q        <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ncount_q <= cfg_wdata_i;
      end
      pos_q          <= pos_d;
      acc_and_q      <= acc_and_d;
      acc_or_q       <= acc_or_d;
      vcnt_q         <= vcnt_d;
      fill_q         <= fill_d;
      rem_q          <= rem_d;
      empty_q        <= empty_d;
      result_valid_o <= cmd_i.emit;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (action_i == bjts_pkg::ACT_QUERY)) begin
      query_q[pos_q] <= data_word_i;
    end
    if (cmd_i.accept && (action_i == bjts_pkg::ACT_DB) && vec_end) begin
      cand_idx_q <= vcnt_q[IW-1:0];
      cand_and_q <= sum_and;
      cand_or_q  <= sum_or;
    end
    for (int j = 0; j < K_MAX; j++) begin
      cell_idx_q[j] <= cell_idx_d[j];
      cell_and_q[j] <= cell_and_d[j];
      cell_or_q[j]  <= cell_or_d[j];
    end
  end

  assign idx_ext = {{OW{1'b0}}, cell_idx_q[0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      neighbour_index_o <= empty_q ? '0 : idx_ext[OW-1:0];
      common_bits_o     <= empty_q ? '0 : sat_count(cell_and_q[0]);
      either_bits_o     <= empty_q ? '0 : sat_count(cell_or_q[0]);
      entry_valid_o     <= !empty_q;
      run_end_o         <= (rem_q == FW'(1));
    end
  end

  a_emit_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (rem_q != '0))
    else $error("report issued with nothing left to report");

  a_insert_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |=> (fill_q != '0))
    else $error("list empty after an insertion");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !entry_valid_o) |-> run_end_o)
    else $error("empty report not marked as the last one");

endmodule

`default_nettype wire

>>> rtl/binary_jaccard_topk_search_top.sv
// ----------------------------------------------------------------------------
// binary_jaccard_topk_search_top
// Brute-force k-nearest-neighbour search over binary vectors by Jaccard
// distance, with a sorted list of the closest vectors.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive action_i, data_word_i and final_word_i with start_i high;
//   the transaction is taken on a rising edge where busy_o is low.
//   Each query or database word is one transaction. The word that closes a
//   database vector also moves it into the cell list in the insertion state,
//   with busy_o high, unless MAX_VECTORS vectors are already counted.
//   A flush reports N neighbours (one when the list is empty): busy_o stays
//   high until the last report, and each result is registered from its report
//   state and shown on result_valid_o for exactly one cycle, with run_end_o on the
//   last. The receiver cannot stall; results must be taken as shown.
//   Configuration: cfg_we_i writes neighbour_count from cfg_wdata_i; the user
//   must write it only while the block is idle (the block does not enforce it).
//   Reset clears the list, counters and accumulators and sets the neighbour
//   count to one; the query words hold no value until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_jaccard_topk_search_top #(
  parameter int unsigned VECTOR_WORDS = bjts_pkg::DEF_VECTOR_WORDS,
  parameter int unsigned K_MAX        = bjts_pkg::DEF_K_MAX,
  parameter int unsigned MAX_VECTORS  = bjts_pkg::DEF_MAX_VECTORS
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start_i,
  output logic                              busy_o,
  input  wire [bjts_pkg::ACT_W-1:0]         action_i,
  input  wire [bjts_pkg::WORD_W-1:0]        data_word_i,
  input  wire                               final_word_i,
  input  wire                               cfg_we_i,
  input  wire [bjts_pkg::NCOUNT_W-1:0]      cfg_wdata_i,
  output logic                              result_valid_o,
  output logic [bjts_pkg::INDEX_W-1:0]      neighbour_index_o,
  output logic [bjts_pkg::COUNT_W-1:0]      common_bits_o,
  output logic [bjts_pkg::COUNT_W-1:0]      either_bits_o,
  output logic                              entry_valid_o,
  output logic                              run_end_o
);

  bjts_pkg::bjts_cmd_t  cmd;
  bjts_pkg::bjts_stat_t stat;

  bjts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  bjts_datapath #(
    .VECTOR_WORDS(VECTOR_WORDS),
    .K_MAX       (K_MAX),
    .MAX_VECTORS (MAX_VECTORS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .action_i         (action_i),
    .data_word_i      (data_word_i),
    .final_word_i     (final_word_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .result_valid_o   (result_valid_o),
    .neighbour_index_o(neighbour_index_o),
    .common_bits_o    (common_bits_o),
    .either_bits_o    (either_bits_o),
    .entry_valid_o    (entry_valid_o),
    .run_end_o        (run_end_o)
  );

endmodule

`default_nettype wire
